/* design/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg: shared definitions for the stream find-and-replace block
// Constants, configuration register codes and the run word passed from the
// classifying front end to the output sequencer.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;
  // most result bytes that one input word can cause
  localparam int MAX_RUN    = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int RUN_IDX_W  = $clog2(MAX_RUN);
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] NEWLINE = 8'h0A;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES      = 2'd0,
    CFG_PATTERN_LENGTH     = 2'd1,
    CFG_REPLACEMENT_BYTES  = 2'd2,
    CFG_REPLACEMENT_LENGTH = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [MAX_RUN-1:0][7:0] bytes;
    logic [CNT_W-1:0]        count;
  } run_t;

  typedef struct packed {
    logic valid;
    run_t run;
  } q_word_t;

endpackage

/* design/sfr_if.sv */
// ----------------------------------------------------------------------------
// sfr_if: stream channels of the find-and-replace block
// Input text channel and output byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

/* design/sfr_front.sv */
// ----------------------------------------------------------------------------
// sfr_front: accept and classify input words
// Holds configuration and the pending partial match, resolves each word as it
// is accepted and pushes the bytes it releases as one run word to the queue.
// ----------------------------------------------------------------------------
module sfr_front (
  input  logic                             clk,
  input  logic                             rst_n,
  sfr_in_if.sink                           in_ch,
  input  logic                             q_full,
  output sfr_pkg::q_word_t                 q_wr,
  input  logic                             cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int MP = sfr_pkg::MAX_PATTERN;
  localparam int CW = sfr_pkg::CNT_W;

  logic [63:0]   pat_r;
  logic [CW-1:0] plen_r;
  logic [63:0]   rep_r;
  logic [CW-1:0] rlen_r;

  logic [MP-1:0][7:0] held_r;
  logic [MP-1:0][7:0] held_nxt;
  logic [CW-1:0]      held_cnt_r;
  logic               line_open_r;

  logic [MP-1:0][7:0]        win;
  logic [MP-1:0][MP-1:0]     eq;
  logic [MP:0]               cand;
  logic [CW-1:0]             n;
  logic [CW-1:0]             sel;
  logic [CW-1:0]             len_sel;
  logic [CW-1:0]             plen_eff;
  logic [CW-1:0]             rlen_eff;
  logic                      full_match;
  logic                      is_nl;
  logic                      accept;
  sfr_pkg::run_t             run;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign n           = held_cnt_r + CW'(1);
  assign is_nl       = (in_ch.in_byte == sfr_pkg::NEWLINE);

  always_comb begin
    plen_eff = plen_r;
    if (plen_r == '0) begin
      plen_eff = CW'(1);
    end else if (plen_r > CW'(MP)) begin
      plen_eff = CW'(MP);
    end
    rlen_eff = rlen_r;
    if (rlen_r > CW'(sfr_pkg::MAX_REPLACEMENT)) begin
      rlen_eff = CW'(sfr_pkg::MAX_REPLACEMENT);
    end
  end

  // held bytes, then the new byte (newline for end of stream)
  always_comb begin
    for (int i = 0; i < MP; i++) begin
      if (CW'(i) < held_cnt_r) begin
        win[i] = held_r[i];
      end else if (in_ch.end_of_stream) begin
        win[i] = sfr_pkg::NEWLINE;
      end else begin
        win[i] = in_ch.in_byte;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < MP; j++) begin
      for (int i = 0; i < MP; i++) begin
        eq[j][i] = (win[j] == pat_r[8*i +: 8]);
      end
    end
  end

  // a start is a candidate if the tail from it is a proper prefix, or the
  // whole window is a full match
  always_comb begin
    logic [CW-1:0] len_s;
    logic          ok;
    for (int s = 0; s <= MP; s++) begin
      len_s = n - CW'(s);
      ok    = (CW'(s) <= n) &&
              ((len_s < plen_eff) || ((len_s == plen_eff) && (s == 0)));
      for (int i = 0; i < MP - s; i++) begin
        if (CW'(i) < len_s) begin
          ok = ok && eq[s+i][i];
        end
      end
      cand[s] = ok;
    end
  end

  always_comb begin
    sel = '0;
    for (int s = MP; s >= 0; s--) begin
      if (cand[s]) begin
        sel = CW'(s);
      end
    end
  end

  assign len_sel    = n - sel;
  assign full_match = (len_sel == plen_eff);

  // keep the unresolved tail, aligned to entry zero
  always_comb begin
    held_nxt = '0;
    for (int j = 0; j < MP; j++) begin
      for (int i = 0; i < MP - j; i++) begin
        if (sel == CW'(j)) begin
          held_nxt[i] = win[j+i];
        end
      end
    end
  end

  always_comb begin
    run = '0;
    for (int i = 0; i < MP; i++) begin
      run.bytes[i] = win[i];
    end
    if (in_ch.end_of_stream) begin
      run.count = held_cnt_r + CW'(line_open_r);
    end else if (is_nl) begin
      run.count = n;
    end else if (full_match) begin
      for (int i = 0; i < sfr_pkg::MAX_REPLACEMENT; i++) begin
        run.bytes[i] = rep_r[8*i +: 8];
      end
      run.count = rlen_eff;
    end else begin
      run.count = sel;
    end
  end

  assign q_wr.valid = accept && (run.count != '0);
  assign q_wr.run   = run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      plen_r <= CW'(1);
      rep_r  <= '0;
      rlen_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfr_pkg::CFG_PATTERN_BYTES:      pat_r  <= cfg_data[63:0];
        sfr_pkg::CFG_PATTERN_LENGTH:     plen_r <= cfg_data[CW-1:0];
        sfr_pkg::CFG_REPLACEMENT_BYTES:  rep_r  <= cfg_data[63:0];
        sfr_pkg::CFG_REPLACEMENT_LENGTH: rlen_r <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r  <= '0;
      line_open_r <= 1'b0;
    end else if (accept) begin
      if (in_ch.end_of_stream || is_nl) begin
        held_cnt_r  <= '0;
        line_open_r <= 1'b0;
      end else begin
        line_open_r <= 1'b1;
        held_cnt_r  <= full_match ? '0 : len_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_ch.end_of_stream && !is_nl && !full_match) begin
      held_r <= held_nxt;
    end
  end

endmodule

/* design/sfr_queue.sv */
// ----------------------------------------------------------------------------
// sfr_queue: run word queue between front and back ends
// Small register FIFO; the head word is presented to the back end.
// ----------------------------------------------------------------------------
module sfr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  sfr_pkg::q_word_t q_wr,
  output logic             q_full,
  output sfr_pkg::q_word_t q_rd,
  input  logic             pop
);

  localparam int PW = sfr_pkg::QPTR_W;
  localparam int NW = sfr_pkg::QCNT_W;

  sfr_pkg::run_t   slots_r [sfr_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [NW-1:0]   cnt_r;
  logic [NW-1:0]   cnt_nxt;
  logic            push;

  assign push    = q_wr.valid && !q_full;
  assign q_full  = (cnt_r == NW'(sfr_pkg::QUEUE_DEPTH));
  assign q_rd.valid = (cnt_r != '0);
  assign q_rd.run   = slots_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= q_wr.run;
    end
  end

endmodule

/* design/sfr_back.sv */
// ----------------------------------------------------------------------------
// sfr_back: output sequencer
// Walks the head run word one byte a cycle, while the output is not stalled,
// into the output register and marks the final byte of each run.
// ----------------------------------------------------------------------------
module sfr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  sfr_pkg::q_word_t q_rd,
  output logic             pop,
  sfr_out_if.source        out_ch
);

  localparam int IW = sfr_pkg::RUN_IDX_W;
  localparam int CW = sfr_pkg::CNT_W;

  logic [IW-1:0] idx_r;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;
  logic          load;
  logic          last;

  assign load = !out_valid_r || out_ch.ready;
  assign last = ((CW'(idx_r) + CW'(1)) == q_rd.run.count);
  assign pop  = load && q_rd.valid && last;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= q_rd.valid;
      if (q_rd.valid) begin
        idx_r <= last ? '0 : idx_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_rd.valid) begin
      out_byte_r <= q_rd.run.bytes[idx_r];
      out_last_r <= last;
    end
  end

endmodule

/* design/stream_find_replace.sv */
// ----------------------------------------------------------------------------
// stream_find_replace: streaming find-and-replace over a byte stream
// Replaces leftmost non-overlapping pattern occurrences within each line.
//
//   channel  dir  payload                      handshake
//   in_ch    in   in_byte, end_of_stream       valid/ready
//   out_ch   out  out_byte, last_of_run        valid/ready
//   cfg_*    in   cfg_index, cfg_data          cfg_we, no back-pressure
//
// One input word is accepted per cycle while the run queue has room; each
// word is resolved in that cycle. The back end emits one output byte per
// cycle while out_ch is not stalled, so a word releasing k bytes holds the
// back end until all k are out; the 4-word queue absorbs replacement bursts.
// Reset is synchronous: configuration, partial match, queue and output clear.
// in_ch.ready drops only while the queue is full; a stalled output holds.
// ----------------------------------------------------------------------------
module stream_find_replace (
  input  logic                             clk,
  input  logic                             rst_n,
  sfr_in_if.sink                           in_ch,
  sfr_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  sfr_pkg::q_word_t q_wr;
  sfr_pkg::q_word_t q_rd;
  logic             q_full;
  logic             pop;

  sfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sfr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .pop    (pop)
  );

  sfr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .pop    (pop),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  // never release a run word that is not there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_rd.valid)
    else $error("run word popped from empty queue");

  // a push can only come from an accepted word, which needs queue room
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.valid |-> !q_full)
    else $error("run word pushed into full queue");

  // a run word always carries at least one byte
  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd.valid |-> (q_rd.run.count != '0))
    else $error("empty run word in queue");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("output valid straight after reset");
`endif

endmodule

/* sim/tb_stream_find_replace.sv */
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_stream_find_replace: self-checking bench for stream find-and-replace
// Pushes text words through the input channel under a series of register
// settings. A scoreboard works out each output byte and its run marker, then
// compares them in order as they leave the block. Both channels stall in
// random bursts, and the bench adds none in the final stretch of the run.
// -----------------------------------------------------------------------------
module tb_stream_find_replace;

  localparam int CLK_HALF   = 5;
  localparam int MAX_CYCLES = 250000;
  localparam int WORD_GOAL  = 370;
  localparam int QUIET_FROM = 320;
  localparam int SETTLE     = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  class replace_board;
    logic [63:0] pat_bytes;
    logic [3:0]  pat_len;
    logic [63:0] rep_bytes;
    logic [3:0]  rep_len;
    logic [7:0]  held [sfr_pkg::MAX_PATTERN];
    int unsigned held_n;
    bit          line_open;
    text_byte_t  expected_q [$];
    int unsigned errors;
    int unsigned bytes_checked;
    int unsigned words_noted;
    int unsigned replacements;

    function new();
      pat_bytes     = '0;
      pat_len       = 4'd1;
      rep_bytes     = '0;
      rep_len       = 4'd0;
      held_n        = 0;
      line_open     = 1'b0;
      errors        = 0;
      bytes_checked = 0;
      words_noted   = 0;
      replacements  = 0;
    endfunction

    function void set_reg(sfr_pkg::cfg_idx_t idx, logic [sfr_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        sfr_pkg::CFG_PATTERN_BYTES:      pat_bytes = value;
        sfr_pkg::CFG_PATTERN_LENGTH:     pat_len   = value[3:0];
        sfr_pkg::CFG_REPLACEMENT_BYTES:  rep_bytes = value;
        sfr_pkg::CFG_REPLACEMENT_LENGTH: rep_len   = value[3:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Resolve one accepted word against the held partial match.
    function void note_word(logic [7:0] b, logic eos);
      logic [7:0] run [$];
      logic [7:0] window [sfr_pkg::MAX_PATTERN+1];
      int         n, plen, rlen, len, s, i;
      bit         ok, done;
      words_noted++;
      if (eos || b == sfr_pkg::NEWLINE) begin
        for (i = 0; i < held_n; i++) run.push_back(held[i]);
        held_n = 0;
        // end of stream closes an open line; a newline always goes out
        if (!eos || line_open) run.push_back(sfr_pkg::NEWLINE);
        line_open = 1'b0;
      end else begin
        line_open = 1'b1;
        n = 0;
        for (i = 0; i < held_n; i++) begin
          window[n] = held[i];
          n++;
        end
        window[n] = b;
        n++;
        plen = (pat_len == 0) ? 1 :
               ((pat_len > sfr_pkg::MAX_PATTERN) ? sfr_pkg::MAX_PATTERN : pat_len);
        done = 1'b0;
        // a full match counts only from the oldest held byte
        for (s = 0; s <= n && !done; s++) begin
          len = n - s;
          if (len < plen || (len == plen && s == 0)) begin
            ok = 1'b1;
            for (i = 0; i < len; i++)
              if (window[s+i] != pat_bytes[8*i +: 8]) ok = 1'b0;
            if (ok) begin
              done = 1'b1;
              if (len == plen) begin
                rlen = (rep_len > sfr_pkg::MAX_REPLACEMENT) ?
                       sfr_pkg::MAX_REPLACEMENT : rep_len;
                for (i = 0; i < rlen; i++) run.push_back(rep_bytes[8*i +: 8]);
                held_n = 0;
                replacements++;
              end else begin
                for (i = 0; i < s; i++) run.push_back(window[i]);
                for (i = 0; i < len; i++) held[i] = window[s+i];
                held_n = len;
              end
            end
          end
        end
      end
      for (i = 0; i < run.size(); i++)
        expected_q.push_back('{data: run[i], last: (i == run.size() - 1)});
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      text_byte_t want;
      bytes_checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte: expected none, actual %h last %b", $time, data, last);
        return;
      end
      want = expected_q.pop_front();
      if (data !== want.data) begin
        errors++;
        $display("%0t: out_byte: expected %h, actual %h", $time, want.data, data);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last_of_run: expected %b, actual %b", $time, want.last, last);
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();

  replace_board board;
  int unsigned  cycles = 0;
  int unsigned  words_sent;
  int unsigned  settings_used;
  bit           quiet;
  int           in_idle_pct;
  logic [63:0]  cur_pat;
  int           cur_plen;

  always #(CLK_HALF) clk = ~clk;

  stream_find_replace uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  task automatic write_reg(sfr_pkg::cfg_idx_t idx, logic [sfr_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    board.set_reg(idx, value);
  endtask

  task automatic apply_settings(logic [63:0] pat, logic [3:0] plen,
                                logic [63:0] rep, logic [3:0] rlen);
    write_reg(sfr_pkg::CFG_PATTERN_BYTES, pat);
    write_reg(sfr_pkg::CFG_PATTERN_LENGTH, {60'd0, plen});
    write_reg(sfr_pkg::CFG_REPLACEMENT_BYTES, rep);
    write_reg(sfr_pkg::CFG_REPLACEMENT_LENGTH, {60'd0, rlen});
    cfg_we   <= 1'b0;
    cur_pat  = pat;
    cur_plen = (plen == 0) ? 1 :
               ((plen > sfr_pkg::MAX_PATTERN) ? sfr_pkg::MAX_PATTERN : plen);
    settings_used++;
  endtask

  task automatic send_word(logic [7:0] b, logic eos);
    if (!quiet && $urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= b;
    in_ch.end_of_stream <= eos;
    do @(posedge clk); while (!in_ch.ready);
    board.note_word(b, eos);
    words_sent++;
  endtask

  // Hold off until every expected byte is out, then let the queue empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 5))
      0, 1:    return 8'h61;
      2:       return 8'h62;
      3:       return 8'h63;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_settings();
    logic [63:0] pat, rep;
    logic [3:0]  plen, rlen;
    int          i;
    for (i = 0; i < 8; i++) pat[8*i +: 8] = pick_letter();
    case ($urandom_range(0, 9))
      0:       pat = '1;
      1:       pat = '0;
      2:       pat[15:8] = sfr_pkg::NEWLINE;
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0:       plen = 4'd0;
      1:       plen = 4'($urandom_range(9, 15));
      2:       plen = 4'd8;
      default: plen = 4'($urandom_range(1, 4));
    endcase
    rep = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       rlen = 4'd0;
      1:       rlen = 4'($urandom_range(9, 15));
      2:       rlen = 4'd8;
      default: rlen = 4'($urandom_range(1, 7));
    endcase
    in_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
    apply_settings(pat, plen, rep, rlen);
  endtask

  // Mostly whole or partial pattern copies, with stray bytes, newlines and
  // stream ends mixed in.
  task automatic random_text(int unsigned goal);
    int unsigned start;
    int          i, cut, k;
    start = words_sent;
    while (words_sent - start < goal) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3: begin
          for (i = 0; i < cur_plen; i++) send_word(cur_pat[8*i +: 8], 1'b0);
        end
        4: begin
          cut = $urandom_range(1, cur_plen);
          for (i = 0; i < cut; i++) send_word(cur_pat[8*i +: 8], 1'b0);
          send_word(pick_letter(), 1'b0);
        end
        5, 6, 7: begin
          k = $urandom_range(0, cur_plen - 1);
          send_word(cur_pat[8*k +: 8], 1'b0);
        end
        8, 9:    send_word(8'($urandom_range(0, 255)), 1'b0);
        10:      send_word(sfr_pkg::NEWLINE, 1'b0);
        default: send_word(8'($urandom_range(0, 255)), 1'b1);
      endcase
    end
  endtask

  initial begin : out_stall
    do @(posedge clk); while (!rst_n);
    forever begin
      if (quiet || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_byte(out_ch.out_byte, out_ch.last_of_run);
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("Timed out after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    board         = new();
    words_sent    = 0;
    settings_used = 0;
    quiet         = 1'b0;
    in_idle_pct   = 25;
    cur_pat       = '0;
    cur_plen      = 1;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= sfr_pkg::CFG_PATTERN_BYTES;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.in_byte       <= '0;
    in_ch.end_of_stream <= 1'b0;
    out_ch.ready        <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: a single zero byte is deleted
    send_word(8'h00, 1'b0);
    send_word(8'h41, 1'b0);
    settle();

    // "ab" -> "XYZ", flush on newline and end of stream
    apply_settings(64'h6261, 4'd2, 64'h5A5958, 4'd3);
    send_word(8'h61, 1'b0);
    send_word(8'h62, 1'b0);
    send_word(8'h61, 1'b0);
    send_word(8'h61, 1'b0);
    send_word(8'h62, 1'b0);
    send_word(8'h61, 1'b0);
    send_word(sfr_pkg::NEWLINE, 1'b0);
    send_word(8'h63, 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b1);
    send_word(8'h61, 1'b0);
    settle();

    // swap the pattern while 'a' is held; zero length acts as one,
    // replacement length saturates
    apply_settings('1, 4'd0, '0, 4'hF);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b1);
    settle();

    // newline inside the pattern never matches; length saturates
    apply_settings(64'h7878_7878_7878_0A78, 4'hF, '0, 4'd0);
    send_word(8'h78, 1'b0);
    send_word(sfr_pkg::NEWLINE, 1'b0);
    settle();

    // empty replacement deletes matches
    apply_settings(64'h7A, 4'd1, 64'h0123_4567_89AB_CDEF, 4'd0);
    send_word(8'h7A, 1'b0);
    send_word(8'h7A, 1'b0);
    send_word(8'h71, 1'b0);
    send_word(8'h7A, 1'b1);

    while (words_sent < WORD_GOAL) begin
      settle();
      random_settings();
      if (words_sent >= QUIET_FROM) quiet = 1'b1;
      random_text($urandom_range(20, 45));
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d input words under %0d register settings.",
             board.words_noted, settings_used);
    $display("%0d output bytes checked, %0d pattern matches replaced.",
             board.bytes_checked, board.replacements);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* stream_find_replace.f */
design/sfr_pkg.sv
design/sfr_if.sv
design/sfr_front.sv
design/sfr_queue.sv
design/sfr_back.sv
design/stream_find_replace.sv
sim/tb_stream_find_replace.sv
